// ----- rtl/door_motor_controller_defines.svh -----
// assertion macros for the door motor controller checker
`ifndef DOOR_MOTOR_CONTROLLER_DEFINES_SVH
`define DOOR_MOTOR_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define DMC_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define DMC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/dmc_pkg.sv -----
// types and constants of the door motor controller
package dmc_pkg;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_ENABLED,
        ST_ERROR_PENDING,
        ST_OBSTACLE_PENDING
    } status_t;

    typedef enum logic [2:0] {
        MODE_UNKNOWN,
        MODE_CLOSED,
        MODE_OPEN,
        MODE_PARTLY_OPEN,
        MODE_OPENING,
        MODE_CLOSING,
        MODE_STOPPED
    } mode_t;

    typedef enum logic [1:0] {
        DUTY_KEEP,
        DUTY_ZERO,
        DUTY_GOAL,
        DUTY_SCALE
    } duty_op_t;

    localparam logic [3:0] OP_TICK           = 4'd0;
    localparam logic [3:0] OP_MOVE           = 4'd1;
    localparam logic [3:0] OP_OPEN           = 4'd2;
    localparam logic [3:0] OP_CLOSE          = 4'd3;
    localparam logic [3:0] OP_SET_SPEED      = 4'd4;
    localparam logic [3:0] OP_STOP           = 4'd5;
    localparam logic [3:0] OP_ESTOP          = 4'd6;
    localparam logic [3:0] OP_RESET_ERROR    = 4'd7;
    localparam logic [3:0] OP_ENABLE         = 4'd8;
    localparam logic [3:0] OP_DISABLE        = 4'd9;
    localparam logic [3:0] OP_CLEAR_OBSTACLE = 4'd10;

    localparam logic [2:0] CFG_MAX_SPEED        = 3'd0;
    localparam logic [2:0] CFG_PWM_TOP          = 3'd1;
    localparam logic [2:0] CFG_OVERCURRENT      = 3'd2;
    localparam logic [2:0] CFG_OPEN_POSITION    = 3'd3;
    localparam logic [2:0] CFG_AUTO_CLOSE_EN    = 3'd4;
    localparam logic [2:0] CFG_AUTO_CLOSE_DELAY = 3'd5;

    localparam logic [2:0] ERR_SYSTEM      = 3'b001;
    localparam logic [2:0] ERR_OVERCURRENT = 3'b010;
    localparam logic [2:0] ERR_OBSTACLE    = 3'b100;

    localparam logic [31:0] STEP_MS = 32'd10;

    // duty = speed * top / 100, saturated: /100 as /4 then reciprocal of 25
    localparam logic [31:0] DUTY_SAT_LIMIT = 32'd6553600;
    localparam logic [21:0] RECIP_25       = 22'd2684355;
    localparam int          RECIP_SHIFT    = 26;

    typedef struct packed {
        mode_t       mode;
        logic        moving;
        logic        en;
        logic        dir;
        logic [2:0]  err;
        logic        obs;
        logic [15:0] pos;
        logic [15:0] goal;
        logic [15:0] spd;
        logic [15:0] spd_goal;
        logic [31:0] last_ms;
        logic [31:0] deadline;
        logic [31:0] n_open;
        logic [31:0] n_close;
        logic [31:0] n_obs;
    } ctl_state_t;

    typedef struct packed {
        ctl_state_t  s;
        duty_op_t    duty_op;
        logic [15:0] duty_arg;
    } work_t;

    typedef struct packed {
        status_t status;
        work_t   w;
    } move_res_t;

    typedef struct packed {
        status_t     status;
        logic        moving;
        mode_t       mode;
        logic [2:0]  err;
        logic [15:0] pos;
        logic        dir;
        logic        en;
        logic        obs;
        logic [31:0] n_open;
        logic [31:0] n_close;
        logic [31:0] n_obs;
    } res_t;

    localparam ctl_state_t CTL_RESET = '{
        mode:     MODE_UNKNOWN,
        moving:   1'b0,
        en:       1'b0,
        dir:      1'b1,
        err:      3'd0,
        obs:      1'b0,
        pos:      16'd0,
        goal:     16'd0,
        spd:      16'd0,
        spd_goal: 16'd0,
        last_ms:  32'd0,
        deadline: 32'd0,
        n_open:   32'd0,
        n_close:  32'd0,
        n_obs:    32'd0
    };

endpackage

// ----- rtl/door_motor_controller.sv -----
// door motor controller top level: command and tick processing with duty scaling
//
// Input channel s_*: one item per command or millisecond tick, valid/ready.
// Result channel m_*: exactly one result item per input item, in order.
// Config channel cfg_*: register index and data, always ready; writes to
// indexes past the register list are ignored. Write only while idle.
// Pipeline: input register, control stage (state update), duty multiply
// stage, divide-by-100 and saturate stage into the result register.
// Throughput: one item per cycle unless the pipeline stalls; each item in
// the control stage sees the state left by the item before it, and the duty
// value is resolved in order further down the pipeline.
// Stall: when a result waits and m_ready is low, the whole pipeline holds
// and s_ready drops; a waiting result does not block the cycle it is taken.
// Reset: aresetn low clears all valids, the control state, the duty and
// restores the register defaults; the door starts in the unknown state,
// disabled, direction opening.
module door_motor_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_op,
    input  logic signed [15:0] s_target_pos,
    input  logic [15:0]        s_speed_request,
    input  logic [31:0]        s_now_ms,
    input  logic [9:0]         s_current_sample,
    input  logic               s_obstacle_n,
    input  logic               s_limit_n,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_moving,
    output logic [2:0]         m_door_state,
    output logic [2:0]         m_error_flags,
    output logic signed [15:0] m_position,
    output logic [15:0]        m_pwm_duty,
    output logic               m_dir_open,
    output logic               m_enabled,
    output logic               m_obstacle_latched,
    output logic [31:0]        m_open_moves,
    output logic [31:0]        m_close_moves,
    output logic [31:0]        m_obstacle_events,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    logic [15:0] max_speed_reg;
    logic [15:0] pwm_top_reg;
    logic [10:0] oc_limit_reg;
    logic [14:0] open_pos_reg;
    logic        ac_enable_reg;
    logic [23:0] ac_delay_reg;

    logic               in_valid_reg;
    logic [3:0]         in_op_reg;
    logic signed [15:0] in_target_reg;
    logic [15:0]        in_speed_req_reg;
    logic [31:0]        in_now_reg;
    logic [9:0]         in_cur_reg;
    logic               in_obs_n_reg;
    logic               in_lim_n_reg;

    dmc_pkg::ctl_state_t state_reg;
    dmc_pkg::work_t      work_next;
    dmc_pkg::status_t    status_next;
    dmc_pkg::res_t       res_next;

    logic              p1_valid_reg;
    dmc_pkg::res_t     p1_res_reg;
    dmc_pkg::duty_op_t p1_duty_op_reg;
    logic [15:0]       p1_duty_arg_reg;

    logic              p2_valid_reg;
    dmc_pkg::res_t     p2_res_reg;
    dmc_pkg::duty_op_t p2_duty_op_reg;
    logic [15:0]       p2_duty_arg_reg;
    logic [31:0]       p2_prod_reg;

    logic          out_valid_reg;
    dmc_pkg::res_t out_res_reg;
    logic [15:0]   duty_reg;
    logic [15:0]   duty_next;
    logic [15:0]   duty_scaled;
    logic [20:0]   quo_in;
    logic [42:0]   quo_prod;

    logic advance;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 16'd100;
            pwm_top_reg   <= 16'd1023;
            oc_limit_reg  <= 11'd2000;
            open_pos_reg  <= 15'd280;
            ac_enable_reg <= 1'b0;
            ac_delay_reg  <= 24'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dmc_pkg::CFG_MAX_SPEED:        max_speed_reg <= cfg_data[15:0];
                dmc_pkg::CFG_PWM_TOP:          pwm_top_reg   <= cfg_data[15:0];
                dmc_pkg::CFG_OVERCURRENT:      oc_limit_reg  <= cfg_data[10:0];
                dmc_pkg::CFG_OPEN_POSITION:    open_pos_reg  <= cfg_data[14:0];
                dmc_pkg::CFG_AUTO_CLOSE_EN:    ac_enable_reg <= cfg_data[0];
                dmc_pkg::CFG_AUTO_CLOSE_DELAY: ac_delay_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
        if (advance && s_valid) begin
            in_op_reg        <= s_op;
            in_target_reg    <= s_target_pos;
            in_speed_req_reg <= s_speed_request;
            in_now_reg       <= s_now_ms;
            in_cur_reg       <= s_current_sample;
            in_obs_n_reg     <= s_obstacle_n;
            in_lim_n_reg     <= s_limit_n;
        end
    end

    function automatic dmc_pkg::move_res_t start_move(dmc_pkg::work_t w,
                                                      logic signed [15:0] target);
        dmc_pkg::move_res_t r;
        r.w      = w;
        r.status = dmc_pkg::ST_OK;
        if (!w.s.en) begin
            r.status = dmc_pkg::ST_NOT_ENABLED;
        end else if (w.s.err != 3'd0) begin
            r.status = dmc_pkg::ST_ERROR_PENDING;
        end else if (w.s.obs) begin
            r.status = dmc_pkg::ST_OBSTACLE_PENDING;
        end else if (target != $signed(w.s.pos)) begin
            if (target > $signed(w.s.pos)) begin
                r.w.s.dir    = 1'b1;
                r.w.s.mode   = dmc_pkg::MODE_OPENING;
                r.w.s.n_open = w.s.n_open + 32'd1;
            end else begin
                r.w.s.dir     = 1'b0;
                r.w.s.mode    = dmc_pkg::MODE_CLOSING;
                r.w.s.n_close = w.s.n_close + 32'd1;
            end
            r.w.duty_op  = dmc_pkg::DUTY_GOAL;
            r.w.duty_arg = w.s.spd_goal;
            r.w.s.goal   = target;
            r.w.s.moving = 1'b1;
        end
        return r;
    endfunction

    function automatic dmc_pkg::work_t do_stop(dmc_pkg::work_t w, logic [14:0] open_pos);
        dmc_pkg::work_t r;
        r = w;
        if (w.s.en) begin
            r.duty_op  = dmc_pkg::DUTY_ZERO;
            r.s.moving = 1'b0;
            r.s.spd    = 16'd0;
            if (w.s.pos == 16'd0) begin
                r.s.mode = dmc_pkg::MODE_CLOSED;
            end else if ($signed(w.s.pos) >= $signed({1'b0, open_pos})) begin
                r.s.mode = dmc_pkg::MODE_OPEN;
            end else begin
                r.s.mode = dmc_pkg::MODE_PARTLY_OPEN;
            end
        end
        return r;
    endfunction

    function automatic dmc_pkg::work_t do_estop(dmc_pkg::work_t w);
        dmc_pkg::work_t r;
        r          = w;
        r.duty_op  = dmc_pkg::DUTY_ZERO;
        r.s.moving = 1'b0;
        r.s.spd    = 16'd0;
        r.s.err    = w.s.err | dmc_pkg::ERR_SYSTEM;
        r.s.mode   = dmc_pkg::MODE_STOPPED;
        return r;
    endfunction

    // control stage: one item against the current state
    always_comb begin
        dmc_pkg::work_t     w;
        dmc_pkg::move_res_t mv;
        logic [31:0]        elapsed;
        w.s         = state_reg;
        w.duty_op   = dmc_pkg::DUTY_KEEP;
        w.duty_arg  = 16'd0;
        status_next = dmc_pkg::ST_OK;
        elapsed     = in_now_reg - state_reg.last_ms;
        mv          = start_move(w, 16'sd0);
        unique case (in_op_reg)
            dmc_pkg::OP_TICK: begin
                if ({1'b0, in_cur_reg} > oc_limit_reg) begin
                    w       = do_estop(w);
                    w.s.err = dmc_pkg::ERR_OVERCURRENT;
                end else if (!in_obs_n_reg) begin
                    w.s.obs   = 1'b1;
                    w.s.n_obs = w.s.n_obs + 32'd1;
                    w         = do_estop(w);
                    w.s.err   = dmc_pkg::ERR_OBSTACLE;
                end else if (w.s.moving) begin
                    if (w.s.spd < w.s.spd_goal) begin
                        w.s.spd    = w.s.spd + 16'd1;
                        w.duty_op  = dmc_pkg::DUTY_SCALE;
                        w.duty_arg = w.s.spd;
                    end else if (w.s.spd > w.s.spd_goal) begin
                        w.s.spd    = w.s.spd - 16'd1;
                        w.duty_op  = dmc_pkg::DUTY_SCALE;
                        w.duty_arg = w.s.spd;
                    end
                    if (elapsed >= dmc_pkg::STEP_MS) begin
                        w.s.pos     = w.s.dir ? w.s.pos + 16'd1 : w.s.pos - 16'd1;
                        w.s.last_ms = in_now_reg;
                    end
                    if (!in_lim_n_reg && !w.s.dir) begin
                        w.s.pos = 16'd0;
                        w       = do_stop(w, open_pos_reg);
                    end
                    if (w.s.pos == w.s.goal) begin
                        w = do_stop(w, open_pos_reg);
                        if (ac_enable_reg && w.s.mode == dmc_pkg::MODE_OPEN) begin
                            w.s.deadline = in_now_reg + {8'd0, ac_delay_reg};
                        end
                    end
                end else if (ac_enable_reg && w.s.mode == dmc_pkg::MODE_OPEN &&
                             in_now_reg >= w.s.deadline) begin
                    // auto-close, status dropped
                    w = mv.w;
                end
            end
            dmc_pkg::OP_MOVE: begin
                mv          = start_move(w, in_target_reg);
                w           = mv.w;
                status_next = mv.status;
            end
            dmc_pkg::OP_OPEN: begin
                mv          = start_move(w, $signed({1'b0, open_pos_reg}));
                w           = mv.w;
                status_next = mv.status;
            end
            dmc_pkg::OP_CLOSE: begin
                w           = mv.w;
                status_next = mv.status;
            end
            dmc_pkg::OP_SET_SPEED: begin
                if (!w.s.en) begin
                    status_next = dmc_pkg::ST_NOT_ENABLED;
                end else begin
                    w.s.spd_goal = (in_speed_req_reg > max_speed_reg) ?
                                   max_speed_reg : in_speed_req_reg;
                end
            end
            dmc_pkg::OP_STOP: begin
                status_next = w.s.en ? dmc_pkg::ST_OK : dmc_pkg::ST_NOT_ENABLED;
                w           = do_stop(w, open_pos_reg);
            end
            dmc_pkg::OP_ESTOP: begin
                w = do_estop(w);
            end
            dmc_pkg::OP_RESET_ERROR: begin
                w.s.err = 3'd0;
                w.s.obs = 1'b0;
            end
            dmc_pkg::OP_ENABLE: begin
                w.s.en = 1'b1;
            end
            dmc_pkg::OP_DISABLE: begin
                w.s.en = 1'b0;
            end
            dmc_pkg::OP_CLEAR_OBSTACLE: begin
                if (!w.s.en) begin
                    status_next = dmc_pkg::ST_NOT_ENABLED;
                end else begin
                    w.s.obs = 1'b0;
                end
            end
            default: begin
            end
        endcase
        work_next = w;
    end

    always_comb begin
        res_next.status  = status_next;
        res_next.moving  = work_next.s.moving;
        res_next.mode    = work_next.s.mode;
        res_next.err     = work_next.s.err;
        res_next.pos     = work_next.s.pos;
        res_next.dir     = work_next.s.dir;
        res_next.en      = work_next.s.en;
        res_next.obs     = work_next.s.obs;
        res_next.n_open  = work_next.s.n_open;
        res_next.n_close = work_next.s.n_close;
        res_next.n_obs   = work_next.s.n_obs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dmc_pkg::CTL_RESET;
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= work_next.s;
            end
        end
        if (advance && in_valid_reg) begin
            p1_res_reg      <= res_next;
            p1_duty_op_reg  <= work_next.duty_op;
            p1_duty_arg_reg <= work_next.duty_arg;
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (advance && p1_valid_reg) begin
            p2_res_reg      <= p1_res_reg;
            p2_duty_op_reg  <= p1_duty_op_reg;
            p2_duty_arg_reg <= p1_duty_arg_reg;
            p2_prod_reg     <= {16'd0, p1_duty_arg_reg} * {16'd0, pwm_top_reg};
        end
    end

    // divide by 100 with saturation, then resolve the duty in item order
    assign quo_in      = p2_prod_reg[22:2];
    assign quo_prod    = {22'd0, quo_in} * {21'd0, dmc_pkg::RECIP_25};
    assign duty_scaled = (p2_prod_reg >= dmc_pkg::DUTY_SAT_LIMIT) ? 16'hFFFF :
                         quo_prod[dmc_pkg::RECIP_SHIFT +: 16];

    always_comb begin
        case (p2_duty_op_reg)
            dmc_pkg::DUTY_ZERO:  duty_next = 16'd0;
            dmc_pkg::DUTY_GOAL:  duty_next = p2_duty_arg_reg;
            dmc_pkg::DUTY_SCALE: duty_next = duty_scaled;
            default:             duty_next = duty_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            duty_reg      <= 16'd0;
        end else if (advance) begin
            out_valid_reg <= p2_valid_reg;
            if (p2_valid_reg) begin
                duty_reg <= duty_next;
            end
        end
        if (advance && p2_valid_reg) begin
            out_res_reg <= p2_res_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_res_reg.status;
    assign m_moving           = out_res_reg.moving;
    assign m_door_state       = out_res_reg.mode;
    assign m_error_flags      = out_res_reg.err;
    assign m_position         = $signed(out_res_reg.pos);
    assign m_pwm_duty         = duty_reg;
    assign m_dir_open         = out_res_reg.dir;
    assign m_enabled          = out_res_reg.en;
    assign m_obstacle_latched = out_res_reg.obs;
    assign m_open_moves       = out_res_reg.n_open;
    assign m_close_moves      = out_res_reg.n_close;
    assign m_obstacle_events  = out_res_reg.n_obs;

endmodule

// ----- rtl/door_motor_controller_checker.sv -----
// port checker for the door motor controller, bound to the top level
`include "door_motor_controller_defines.svh"

module door_motor_controller_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic               m_moving,
    input logic [2:0]         m_door_state,
    input logic [2:0]         m_error_flags,
    input logic signed [15:0] m_position,
    input logic               m_enabled,
    input logic               m_obstacle_latched
);

    `DMC_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_position) && $stable(m_status), "stalled result item changed")

    `DMC_ASSERT_IMPLY(a_not_enabled, m_valid && m_status == dmc_pkg::ST_NOT_ENABLED, !m_enabled, "not-enabled status while enabled")

    `DMC_ASSERT_IMPLY(a_error_pending, m_valid && m_status == dmc_pkg::ST_ERROR_PENDING, m_error_flags != 3'd0, "error status without error flags")

    `DMC_ASSERT_IMPLY(a_obstacle_pending, m_valid && m_status == dmc_pkg::ST_OBSTACLE_PENDING, m_obstacle_latched, "obstacle status without latched obstacle")

    `DMC_ASSERT_IMPLY(a_moving_mode, m_valid && m_moving, m_door_state == dmc_pkg::MODE_OPENING || m_door_state == dmc_pkg::MODE_CLOSING, "moving outside opening or closing")

endmodule

bind door_motor_controller door_motor_controller_checker u_door_motor_controller_checker (.*);
